[src/isfr_pkg.sv]
// Shared types, constants and register codes of the servo frame receiver.
package isfr_pkg;

  localparam int FRAME_BYTES_DEF = 32;
  localparam int MAX_CH          = 14;
  localparam int POS_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_BASE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE_CHANNEL   = 3'd4;

  // Register reset values.
  localparam logic [7:0]  HEADER_FIRST_RST       = 8'd32;
  localparam logic [7:0]  HEADER_SECOND_RST      = 8'd64;
  localparam logic [15:0] CHECKSUM_BASE_RST      = 16'd65535;
  localparam logic [15:0] FAILSAFE_THRESHOLD_RST = 16'd1975;
  localparam logic [3:0]  FAILSAFE_CHANNEL_RST   = 4'd10;

  typedef enum logic [1:0] {
    MODE_HUNT0,
    MODE_HUNT1,
    MODE_SYNCED,
    MODE_VERIFIED
  } sync_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_CHECK,
    ST_FS_CMP,
    ST_RD,
    ST_LOAD
  } seq_state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        fs_active;
    logic        last;
  } out_item_t;

endpackage

[src/isfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module isfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 14
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

[src/ibus_servo_frame_receiver.sv]
// Top level of the serial servo frame receiver: sequencer, shared adder and channel store.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | isfr_pkg::in_item_t  (rx_byte, line_error)
//   out_    | output    | out_valid / out_stall | isfr_pkg::out_item_t (index, value, flags)
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each input byte is taken in the idle state, then run through the shared 16-bit
// add/subtract unit in the process state. The final byte of a synced frame then goes on
// to the checksum compare. After that, a good frame runs the fail-safe compare, when the
// fail-safe channel lies in the store, and a read and a load state per channel, since
// every channel comes out of the single read port of the channel store.
// Reset is synchronous and clears all control state and the configuration registers;
// the channel store is not cleared. A stalled output holds the sequencer in place.
module ibus_servo_frame_receiver #(
  parameter int FRAME_BYTES = isfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  isfr_pkg::in_item_t                   in_data,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output isfr_pkg::out_item_t                  out_data,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [isfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [isfr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import isfr_pkg::*;

  // Channel count follows from the frame size, capped at MAX_CH.
  localparam int RAW_CH = (FRAME_BYTES - 4) / 2;
  localparam int NUM_CH = (RAW_CH < MAX_CH) ? RAW_CH : MAX_CH;
  localparam int CH_AW  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

  localparam logic [POS_W-1:0] POS_TRAIL_LO = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_FIRST_PL = POS_W'(2);
  localparam logic [CH_AW-1:0] CH_LAST      = CH_AW'(NUM_CH - 1);

  // Configuration registers.
  logic [7:0]  header_first_r;
  logic [7:0]  header_second_r;
  logic [15:0] checksum_base_r;
  logic [15:0] failsafe_threshold_r;
  logic [3:0]  failsafe_channel_r;

  // Sequencer and frame state.
  seq_state_t  state_r, state_nxt;
  sync_mode_t  mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        mismatch_r, mismatch_nxt;
  logic [7:0]  pending_r, pending_nxt;
  logic [7:0]  trailer_r, trailer_nxt;
  logic        flag_r, flag_nxt;
  logic [CH_AW-1:0] ch_cnt_r, ch_cnt_nxt;

  // Latched input transaction.
  logic [7:0]  byte_r;
  logic        err_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  // Shared add/subtract unit.
  logic [15:0] alu_a, alu_b;
  logic        alu_sub;
  logic [16:0] alu_res;

  // Channel store access.
  logic             st_we;
  logic [CH_AW-1:0] st_waddr;
  logic [CH_AW-1:0] st_raddr;
  logic [15:0]      st_rdata;

  logic [POS_W-1:0] pl_off;
  logic [POS_W-2:0] pl_ch;
  logic             pl_in_store;
  logic             frame_good;
  logic             fs_in_range;
  logic             slot_free;
  logic             synced;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign synced      = (mode_r == MODE_SYNCED) || (mode_r == MODE_VERIFIED);
  assign pl_off      = pos_r - POS_FIRST_PL;
  assign pl_ch       = pl_off[POS_W-1:1];
  assign pl_in_store = (pos_r >= POS_FIRST_PL) && (pl_ch < (POS_W-1)'(NUM_CH));
  assign fs_in_range = (failsafe_channel_r < 4'(NUM_CH));
  assign slot_free   = !out_valid_r || !out_stall;
  assign frame_good  = !mismatch_r && (alu_res[15:0] == {byte_r, trailer_r});

  // The shared arithmetic unit: a + b, or a - b with the carry out as the no-borrow flag.
  always_comb begin
    alu_a   = sum_r;
    alu_b   = {8'd0, byte_r};
    alu_sub = 1'b0;
    case (state_r)
      ST_PROC: begin
        if (mode_r == MODE_HUNT1) begin
          alu_a = {8'd0, header_first_r};
          alu_b = {8'd0, header_second_r};
        end
      end
      ST_CHECK: begin
        alu_a   = checksum_base_r;
        alu_b   = sum_r;
        alu_sub = 1'b1;
      end
      ST_FS_CMP: begin
        alu_a   = failsafe_threshold_r;
        alu_b   = st_rdata;
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
    alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {16'd0, alu_sub};
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        if (!err_r && synced && (pos_r == POS_LAST)) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (!frame_good) begin
          state_nxt = ST_IDLE;
        end else if (fs_in_range) begin
          state_nxt = ST_FS_CMP;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_FS_CMP: begin
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          state_nxt = (ch_cnt_r == CH_LAST) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    mismatch_nxt  = mismatch_r;
    pending_nxt   = pending_r;
    trailer_nxt   = trailer_r;
    flag_nxt      = flag_r;
    ch_cnt_nxt    = ch_cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    st_we         = 1'b0;
    st_waddr      = pl_ch[CH_AW-1:0];
    st_raddr      = ch_cnt_r;

    case (state_r)
      ST_PROC: begin
        if (err_r) begin
          mode_nxt     = MODE_HUNT0;
          pos_nxt      = '0;
          sum_nxt      = '0;
          mismatch_nxt = 1'b0;
        end else begin
          case (mode_r)
            MODE_HUNT0: begin
              if (byte_r == header_first_r) begin
                mode_nxt = MODE_HUNT1;
              end
            end
            MODE_HUNT1: begin
              if (byte_r == header_second_r) begin
                mode_nxt     = MODE_SYNCED;
                pos_nxt      = POS_FIRST_PL;
                sum_nxt      = alu_res[15:0];
                mismatch_nxt = 1'b0;
              end else begin
                mode_nxt     = MODE_HUNT0;
                pos_nxt      = '0;
                sum_nxt      = '0;
                mismatch_nxt = 1'b0;
              end
            end
            default: begin
              // Later frames recheck both header bytes in place.
              if ((pos_r == POS_W'(0)) && (byte_r != header_first_r)) begin
                mismatch_nxt = 1'b1;
              end
              if ((pos_r == POS_W'(1)) && (byte_r != header_second_r)) begin
                mismatch_nxt = 1'b1;
              end
              if (pos_r < POS_TRAIL_LO) begin
                sum_nxt = alu_res[15:0];
                if (pl_in_store) begin
                  if (!pl_off[0]) begin
                    pending_nxt = byte_r;
                  end else begin
                    st_we = 1'b1;
                  end
                end
                pos_nxt = pos_r + POS_W'(1);
              end else if (pos_r == POS_TRAIL_LO) begin
                trailer_nxt = byte_r;
                pos_nxt     = pos_r + POS_W'(1);
              end
            end
          endcase
        end
      end
      ST_CHECK: begin
        // Fetch the fail-safe channel while the checksum is compared.
        st_raddr   = failsafe_channel_r[CH_AW-1:0];
        ch_cnt_nxt = '0;
        pos_nxt      = '0;
        sum_nxt      = '0;
        mismatch_nxt = 1'b0;
        if (frame_good) begin
          mode_nxt = MODE_VERIFIED;
          if (!fs_in_range) begin
            flag_nxt = 1'b0;
          end
        end else begin
          mode_nxt = MODE_HUNT0;
        end
      end
      ST_FS_CMP: begin
        // No carry out of threshold minus channel means the channel is larger.
        flag_nxt = !alu_res[16];
      end
      ST_LOAD: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.channel_index = 4'(ch_cnt_r);
          out_data_nxt.channel_value = st_rdata;
          out_data_nxt.fs_active     = flag_r;
          out_data_nxt.last          = (ch_cnt_r == CH_LAST);
          if (ch_cnt_r != CH_LAST) begin
            ch_cnt_nxt = ch_cnt_r + CH_AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_HUNT0;
      pos_r       <= '0;
      sum_r       <= '0;
      mismatch_r  <= 1'b0;
      pending_r   <= '0;
      trailer_r   <= '0;
      flag_r      <= 1'b0;
      ch_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      mismatch_r  <= mismatch_nxt;
      pending_r   <= pending_nxt;
      trailer_r   <= trailer_nxt;
      flag_r      <= flag_nxt;
      ch_cnt_r    <= ch_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if ((state_r == ST_IDLE) && in_valid) begin
      byte_r <= in_data.rx_byte;
      err_r  <= in_data.line_error;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r       <= HEADER_FIRST_RST;
      header_second_r      <= HEADER_SECOND_RST;
      checksum_base_r      <= CHECKSUM_BASE_RST;
      failsafe_threshold_r <= FAILSAFE_THRESHOLD_RST;
      failsafe_channel_r   <= FAILSAFE_CHANNEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_FIRST:       header_first_r       <= cfg_data[7:0];
        CFG_HEADER_SECOND:      header_second_r      <= cfg_data[7:0];
        CFG_CHECKSUM_BASE:      checksum_base_r      <= cfg_data;
        CFG_FAILSAFE_THRESHOLD: failsafe_threshold_r <= cfg_data;
        CFG_FAILSAFE_CHANNEL:   failsafe_channel_r   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Channel store: written from the payload pairs, swept out after a good frame.
  isfr_ram #(
    .WIDTH (16),
    .DEPTH (NUM_CH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data ({byte_r, pending_r}),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

endmodule

[src/isfr_checker.sv]
// Port-level checker for the servo frame receiver, bound to the top level.
module isfr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input isfr_pkg::out_item_t             out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  import isfr_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After every byte transaction the input reports busy before it takes another byte.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on two consecutive cycles");

  // The block stays busy while a frame's channels are still going out.
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input open in the middle of a frame's results");

  // A result never names a channel past the store.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.channel_index < 4'(MAX_CH)))
    else $error("result channel index out of range");

  // The configuration port never holds off a write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind ibus_servo_frame_receiver isfr_checker u_isfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
